@@ src/rllp_pkg.sv @@
package rllp_pkg;

    localparam int SLOT_W      = 4;
    localparam int NODE_W      = 8;
    localparam int COPY_W      = 2;
    localparam int CFG_W       = 5;
    localparam int LOAD_W      = 16;
    localparam int COPY_FIELDS = 3;

    localparam logic [LOAD_W-1:0] LOAD_MAX = 16'hFFFF;

    localparam logic ACT_ASSIGN = 1'b0;
    localparam logic ACT_PICK   = 1'b1;

    localparam logic [CFG_W-1:0] CFG_RESET = 5'd16;

    typedef struct packed {
        logic              action;
        logic [SLOT_W-1:0] slot;
        logic [NODE_W-1:0] node_ident;
        logic [NODE_W-1:0] copy0_node;
        logic [NODE_W-1:0] copy1_node;
        logic [NODE_W-1:0] copy2_node;
    } in_item_t;

    typedef struct packed {
        logic              found;
        logic [COPY_W-1:0] copy_index;
        logic [SLOT_W-1:0] chosen_slot;
    } out_item_t;

    // table port strobes from the sequencer
    typedef struct packed {
        logic rd_en;
        logic node_we;
        logic cnt_we;
    } tbl_ctrl_t;

endpackage

@@ src/rllp_copy_match.sv @@
module rllp_copy_match #(
    parameter int COPIES = 3
) (
    input  logic [rllp_pkg::NODE_W-1:0] node,
    input  rllp_pkg::in_item_t          item,
    output logic                        hit,
    output logic [rllp_pkg::COPY_W-1:0] copy_idx
);

    localparam int NCHK = (COPIES < rllp_pkg::COPY_FIELDS) ? COPIES : rllp_pkg::COPY_FIELDS;

    logic [rllp_pkg::NODE_W-1:0] copies [rllp_pkg::COPY_FIELDS];

    assign copies[0] = item.copy0_node;
    assign copies[1] = item.copy1_node;
    assign copies[2] = item.copy2_node;

    // scan downward so the lowest matching copy wins
    always_comb
    begin
        hit      = 1'b0;
        copy_idx = '0;
        for (int c = NCHK - 1; c >= 0; c--)
        begin
            if (copies[c] == node)
            begin
                hit      = 1'b1;
                copy_idx = rllp_pkg::COPY_W'(c);
            end
        end
    end

endmodule

@@ src/rllp_tables.sv @@
module rllp_tables #(
    parameter int MAX_NODES = 16,
    parameter int IDX_W     = 4
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  rllp_pkg::tbl_ctrl_t         ctrl,
    input  logic [IDX_W-1:0]            rd_addr,
    input  logic [IDX_W-1:0]            wr_addr,
    input  logic [rllp_pkg::NODE_W-1:0] node_wdata,
    input  logic [rllp_pkg::LOAD_W-1:0] cnt_wdata,
    output logic [rllp_pkg::NODE_W-1:0] rd_node,
    output logic [rllp_pkg::LOAD_W-1:0] rd_cnt
);

    logic [rllp_pkg::NODE_W-1:0] node_mem_reg [MAX_NODES];
    logic [rllp_pkg::LOAD_W-1:0] cnt_mem_reg  [MAX_NODES];

    // an entry not yet written reads as zero
    logic [MAX_NODES-1:0] node_vld_reg;
    logic [MAX_NODES-1:0] cnt_vld_reg;

    logic [rllp_pkg::NODE_W-1:0] node_q_reg;
    logic [rllp_pkg::LOAD_W-1:0] cnt_q_reg;
    logic                        node_qv_reg;
    logic                        cnt_qv_reg;

    always_ff @(posedge clk)
    begin
        if (ctrl.node_we)
        begin
            node_mem_reg[wr_addr] <= node_wdata;
        end
        if (ctrl.cnt_we)
        begin
            cnt_mem_reg[wr_addr] <= cnt_wdata;
        end
        if (ctrl.rd_en)
        begin
            node_q_reg <= node_mem_reg[rd_addr];
            cnt_q_reg  <= cnt_mem_reg[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            node_vld_reg <= '0;
            cnt_vld_reg  <= '0;
            node_qv_reg  <= 1'b0;
            cnt_qv_reg   <= 1'b0;
        end
        else
        begin
            if (ctrl.node_we)
            begin
                node_vld_reg[wr_addr] <= 1'b1;
            end
            if (ctrl.cnt_we)
            begin
                cnt_vld_reg[wr_addr] <= 1'b1;
            end
            if (ctrl.rd_en)
            begin
                node_qv_reg <= node_vld_reg[rd_addr];
                cnt_qv_reg  <= cnt_vld_reg[rd_addr];
            end
        end
    end

    assign rd_node = node_qv_reg ? node_q_reg : '0;
    assign rd_cnt  = cnt_qv_reg  ? cnt_q_reg  : '0;

endmodule

@@ src/replica_least_loaded_picker_top.sv @@
// Assign transfer: the result goes through ST_FINISH to the output register before the
// next input is taken. Pick transfer: the scan walks the active slots (min of nodes_in_use
// and MAX_NODES) one slot per cycle through the table read port and the single load
// comparator, then ST_UPDATE and ST_FINISH register the result. Reset (rst_n low, async)
// clears control state and the table valid bits, so all node ids and load counters read
// as zero right away; nodes_in_use resets to 16.
module replica_least_loaded_picker_top #(
    parameter int MAX_NODES = 16,
    parameter int COPIES    = 3
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  rllp_pkg::in_item_t                  in_item,
    output logic                                out_valid,
    input  logic                                out_ready,
    output rllp_pkg::out_item_t                 out_item,
    input  logic                                cfg_we,
    input  logic [rllp_pkg::CFG_W-1:0]          cfg_data
);

    localparam int IDX_W  = $clog2(MAX_NODES);
    localparam int LIM_BW = $clog2(MAX_NODES + 1);
    // wide enough for the config value, the slot field and the slot count
    localparam int LIM_W  = (LIM_BW > rllp_pkg::CFG_W) ? LIM_BW : rllp_pkg::CFG_W;
    localparam logic [LIM_W-1:0] MAX_LIM = LIM_W'(MAX_NODES);

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_SCAN   = 4'b0010,
        ST_UPDATE = 4'b0100,
        ST_FINISH = 4'b1000
    } state_t;

    // control state
    state_t                     state_reg, state_next;
    logic                       out_valid_reg, out_valid_next;
    logic [rllp_pkg::CFG_W-1:0] cfg_reg;
    logic                       pend_reg, pend_next;
    logic                       have_reg, have_next;

    // payload
    rllp_pkg::in_item_t          item_reg, item_next;
    logic [LIM_W-1:0]            lim_reg, lim_next;
    logic [LIM_W-1:0]            idx_reg, idx_next;
    logic [IDX_W-1:0]            pend_slot_reg, pend_slot_next;
    logic [rllp_pkg::LOAD_W-1:0] best_reg, best_next;
    logic [IDX_W-1:0]            best_slot_reg, best_slot_next;
    logic [rllp_pkg::COPY_W-1:0] best_copy_reg, best_copy_next;
    rllp_pkg::out_item_t         res_reg, res_next;
    rllp_pkg::out_item_t         out_item_reg, out_item_next;

    // datapath
    logic                        in_fire;
    logic [LIM_W-1:0]            cfg_ext;
    logic [LIM_W-1:0]            lim_now;
    logic [LIM_W-1:0]            slot_ext;
    logic [LIM_W-1:0]            best_slot_ext;
    logic                        slot_ok;
    logic                        issue;
    logic                        better;
    logic                        hit;
    logic [rllp_pkg::COPY_W-1:0] hit_copy;
    rllp_pkg::tbl_ctrl_t         ctrl;
    logic [IDX_W-1:0]            wr_addr;
    logic [rllp_pkg::NODE_W-1:0] rd_node;
    logic [rllp_pkg::LOAD_W-1:0] rd_cnt;
    logic [rllp_pkg::LOAD_W-1:0] cnt_wdata;

    assign in_ready  = (state_reg == ST_IDLE);
    assign in_fire   = in_valid && in_ready;
    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

    // active slot count, saturated to the table size
    assign cfg_ext = LIM_W'(cfg_reg);
    assign lim_now = (cfg_ext > MAX_LIM) ? MAX_LIM : cfg_ext;

    // assign to a slot beyond the table is dropped
    assign slot_ext      = LIM_W'(in_item.slot);
    assign slot_ok       = (slot_ext < MAX_LIM);
    assign best_slot_ext = LIM_W'(best_slot_reg);

    // scan issues one table read per cycle; the table registers the read data
    assign issue = (state_reg == ST_SCAN) && (idx_reg < lim_reg);

    rllp_copy_match #(
        .COPIES   (COPIES)
    ) u_match (
        .node     (rd_node),
        .item     (item_reg),
        .hit      (hit),
        .copy_idx (hit_copy)
    );

    // shared load comparator: strict less-than keeps the lowest slot on a tie
    assign better = pend_reg && hit && (!have_reg || (rd_cnt < best_reg));

    assign ctrl.rd_en   = issue;
    assign ctrl.node_we = in_fire && (in_item.action == rllp_pkg::ACT_ASSIGN) && slot_ok;
    assign ctrl.cnt_we  = (state_reg == ST_UPDATE) && have_reg;
    assign wr_addr      = ctrl.node_we ? slot_ext[IDX_W-1:0] : best_slot_reg;
    assign cnt_wdata    = (best_reg == rllp_pkg::LOAD_MAX) ? best_reg
                                                           : best_reg + 16'd1;

    rllp_tables #(
        .MAX_NODES  (MAX_NODES),
        .IDX_W      (IDX_W)
    ) u_tables (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctrl       (ctrl),
        .rd_addr    (idx_reg[IDX_W-1:0]),
        .wr_addr    (wr_addr),
        .node_wdata (in_item.node_ident),
        .cnt_wdata  (cnt_wdata),
        .rd_node    (rd_node),
        .rd_cnt     (rd_cnt)
    );

    // sequencer
    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg;
        pend_next      = pend_reg;
        have_next      = have_reg;
        item_next      = item_reg;
        lim_next       = lim_reg;
        idx_next       = idx_reg;
        pend_slot_next = pend_slot_reg;
        best_next      = best_reg;
        best_slot_next = best_slot_reg;
        best_copy_next = best_copy_reg;
        res_next       = res_reg;
        out_item_next  = out_item_reg;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    item_next = in_item;
                    if (in_item.action == rllp_pkg::ACT_PICK)
                    begin
                        state_next = ST_SCAN;
                        lim_next   = lim_now;
                        idx_next   = '0;
                        pend_next  = 1'b0;
                        have_next  = 1'b0;
                    end
                    else
                    begin
                        state_next           = ST_FINISH;
                        res_next.found       = slot_ok;
                        res_next.copy_index  = '0;
                        res_next.chosen_slot = slot_ok ? in_item.slot : '0;
                    end
                end
            end
            ST_SCAN:
            begin
                pend_next      = issue;
                pend_slot_next = idx_reg[IDX_W-1:0];
                if (issue)
                begin
                    idx_next = idx_reg + LIM_W'(1);
                end
                if (better)
                begin
                    have_next      = 1'b1;
                    best_next      = rd_cnt;
                    best_slot_next = pend_slot_reg;
                    best_copy_next = hit_copy;
                end
                // last read is evaluated in this same cycle
                if (!issue)
                begin
                    state_next = ST_UPDATE;
                end
            end
            ST_UPDATE:
            begin
                state_next           = ST_FINISH;
                res_next.found       = have_reg;
                res_next.copy_index  = have_reg ? best_copy_reg : '0;
                res_next.chosen_slot = have_reg ? best_slot_ext[rllp_pkg::SLOT_W-1:0] : '0;
            end
            ST_FINISH:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_item_next  = res_reg;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            cfg_reg       <= rllp_pkg::CFG_RESET;
            pend_reg      <= 1'b0;
            have_reg      <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            pend_reg      <= pend_next;
            have_reg      <= have_next;
            if (cfg_we)
            begin
                cfg_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg      <= item_next;
        lim_reg       <= lim_next;
        idx_reg       <= idx_next;
        pend_slot_reg <= pend_slot_next;
        best_reg      <= best_next;
        best_slot_reg <= best_slot_next;
        best_copy_reg <= best_copy_next;
        res_reg       <= res_next;
        out_item_reg  <= out_item_next;
    end

    // saturating increment never wraps to zero
    a_cnt_no_wrap: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.cnt_we |-> (cnt_wdata != '0))
        else $error("load counter write wrapped");

    // read pipeline only runs during the scan
    a_pend_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
        pend_reg |-> (state_reg == ST_SCAN))
        else $error("table read pending outside scan");

    // chosen slot lies among the active slots
    a_best_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == ST_UPDATE) && have_reg) |-> (best_slot_ext < lim_reg))
        else $error("chosen slot outside active range");

    // a transfer in blocks further input until the result is produced
    a_busy_after_in: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |=> !in_ready)
        else $error("input accepted while busy");

endmodule

@@ test/tb_replica_least_loaded_picker_top.sv @@
module tb_replica_least_loaded_picker_top;

    timeunit 1ns;
    timeprecision 1ps;

    import rllp_pkg::*;

    // Table depth as instantiated; slots beyond nodes_in_use sit out of every pick.
    localparam int TABLE_DEPTH = 16;
    // Settling margin, longer than the longest pick, given to the block before a
    // register write or the final check.
    localparam int SETTLE      = 25;
    // Cycles with neither a request nor a result transfer before we give up.
    localparam int STALL_LIMIT = 5000;
    localparam int MAX_GAP     = 40;
    localparam int HOLD_OFF    = 400;

    // Node ids that the random traffic reuses so that picks find replicas.
    localparam logic [NODE_W-1:0] NODE_POOL [6] = '{8'h00, 8'hFF, 8'h3C, 8'hA5, 8'h5A, 8'h81};

    typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_e;

    // One line of the directed table: either a register write or a request.
    // Where typed is set the result is written out by hand, otherwise the
    // predictor supplies it.
    typedef struct packed {
        row_kind_e         kind;
        logic [CFG_W-1:0]  cfg;
        in_item_t          req;
        logic              typed;
        out_item_t         want;
    } dir_row_t;

    localparam dir_row_t DIRECTED [19] = '{
        // fresh table: every slot holds node 0, all loads equal -> slot 0
        '{ROW_ITEM, 5'd0, '{ACT_PICK,   4'h0, 8'h00, 8'h00, 8'h00, 8'h00}, 1'b1, '{1'b1, 2'd0, 4'd0}},
        // no slot holds any of the copies
        '{ROW_ITEM, 5'd0, '{ACT_PICK,   4'h0, 8'h00, 8'h01, 8'h02, 8'h03}, 1'b1, '{1'b0, 2'd0, 4'd0}},
        '{ROW_ITEM, 5'd0, '{ACT_ASSIGN, 4'hF, 8'hFF, 8'h00, 8'h00, 8'h00}, 1'b1, '{1'b1, 2'd0, 4'd15}},
        // last copy is the only match, top slot
        '{ROW_ITEM, 5'd0, '{ACT_PICK,   4'h0, 8'h00, 8'h07, 8'h08, 8'hFF}, 1'b1, '{1'b1, 2'd2, 4'd15}},
        '{ROW_ITEM, 5'd0, '{ACT_ASSIGN, 4'h0, 8'hAA, 8'h00, 8'h00, 8'h00}, 1'b1, '{1'b1, 2'd0, 4'd0}},
        // equal loads on slots 0 and 15: lower slot wins
        '{ROW_ITEM, 5'd0, '{ACT_PICK,   4'h0, 8'h00, 8'hAA, 8'hFF, 8'hAA}, 1'b0, '0},
        '{ROW_ITEM, 5'd0, '{ACT_ASSIGN, 4'h5, 8'h5A, 8'h00, 8'h00, 8'h00}, 1'b1, '{1'b1, 2'd0, 4'd5}},
        // repeated copy node: first matching copy reported
        '{ROW_ITEM, 5'd0, '{ACT_PICK,   4'h0, 8'h00, 8'h33, 8'h5A, 8'h5A}, 1'b0, '0},
        '{ROW_ITEM, 5'd0, '{ACT_PICK,   4'h0, 8'h00, 8'h00, 8'h00, 8'h00}, 1'b0, '0},
        // nobody takes part
        '{ROW_CFG,  5'd0, '0, 1'b0, '0},
        '{ROW_ITEM, 5'd0, '{ACT_PICK,   4'h0, 8'h00, 8'h00, 8'hAA, 8'hFF}, 1'b1, '{1'b0, 2'd0, 4'd0}},
        // only slot 0 takes part
        '{ROW_CFG,  5'd1, '0, 1'b0, '0},
        '{ROW_ITEM, 5'd0, '{ACT_PICK,   4'h0, 8'h00, 8'h11, 8'h22, 8'hAA}, 1'b1, '{1'b1, 2'd2, 4'd0}},
        '{ROW_ITEM, 5'd0, '{ACT_PICK,   4'h0, 8'h00, 8'hFF, 8'h5A, 8'h00}, 1'b1, '{1'b0, 2'd0, 4'd0}},
        // above the table depth: behaves as the full table
        '{ROW_CFG,  5'd31, '0, 1'b0, '0},
        '{ROW_ITEM, 5'd0, '{ACT_PICK,   4'h0, 8'h00, 8'hFF, 8'h5A, 8'h00}, 1'b0, '0},
        '{ROW_ITEM, 5'd0, '{ACT_ASSIGN, 4'hF, 8'h00, 8'hFF, 8'hFF, 8'hFF}, 1'b1, '{1'b1, 2'd0, 4'd15}},
        '{ROW_CFG,  5'd16, '0, 1'b0, '0},
        // all-ones payload, but no slot holds node FF any more
        '{ROW_ITEM, 5'd0, '{ACT_PICK,   4'hF, 8'hFF, 8'hFF, 8'hFF, 8'hFF}, 1'b1, '{1'b0, 2'd0, 4'd0}}
    };

    // Random phases: register value (-1 picks one at random), sender idle
    // percentage, receiver stall percentage, number of requests.
    typedef struct packed {
        int cfg;
        int send_pct;
        int recv_pct;
        int items;
    } phase_t;

    localparam phase_t PHASES [8] = '{
        '{16,  0,  0, 160},
        '{ 1, 74,  0, 100},
        '{16,  0, 74, 160},
        '{ 0,  8,  8,  40},
        '{31,  8,  8, 160},
        '{-1, 74,  0, 140},
        '{ 4,  0, 74, 140},
        '{16,  0,  0, 230}
    };

    logic      clk;
    logic      rst_n;
    logic      in_valid;
    logic      in_ready;
    in_item_t  in_item;
    logic      out_valid;
    logic      out_ready;
    out_item_t out_item;
    logic      cfg_we;
    logic [CFG_W-1:0] cfg_data;

    // Shadow of the block's table, loads and register.
    logic [NODE_W-1:0] node_ids   [TABLE_DEPTH];
    logic [LOAD_W-1:0] slot_loads [TABLE_DEPTH];
    logic [CFG_W-1:0]  slots_in_use;

    out_item_t pending_results [$];

    int send_idle_pct;
    int recv_stall_pct;
    int hold_left;
    int errors;
    int requests_sent;
    int picks_missed;
    int results_checked;
    int cfg_writes;
    int quiet_cycles;

    replica_least_loaded_picker_top #(
        .MAX_NODES (TABLE_DEPTH),
        .COPIES    (COPY_FIELDS)
    ) DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_item   (in_item),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_item  (out_item),
        .cfg_we    (cfg_we),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Expected result of one request; updates the shadow table and loads
    // exactly as the block does on acceptance.
    function automatic out_item_t pick_replica(input in_item_t req);
        out_item_t         res;
        logic [NODE_W-1:0] copies [COPY_FIELDS];
        int                lim;
        int                hit;
        int                best_slot;
        int                best_copy;
        bit                have;
        res       = '0;
        have      = 1'b0;
        best_slot = 0;
        best_copy = 0;
        if (req.action == ACT_ASSIGN)
        begin
            node_ids[req.slot] = req.node_ident;
            res.found          = 1'b1;
            res.chosen_slot    = req.slot;
            return res;
        end
        copies[0] = req.copy0_node;
        copies[1] = req.copy1_node;
        copies[2] = req.copy2_node;
        lim = (slots_in_use > TABLE_DEPTH) ? TABLE_DEPTH : int'(slots_in_use);
        for (int s = 0; s < lim; s++)
        begin
            hit = -1;
            for (int c = COPY_FIELDS - 1; c >= 0; c--)
                if (copies[c] == node_ids[s])
                    hit = c;
            // strict less-than keeps the lowest slot on equal loads
            if (hit >= 0 && (!have || slot_loads[s] < slot_loads[best_slot]))
            begin
                have      = 1'b1;
                best_slot = s;
                best_copy = hit;
            end
        end
        if (have)
        begin
            if (slot_loads[best_slot] != LOAD_MAX)
                slot_loads[best_slot] = slot_loads[best_slot] + 1'b1;
            res.found       = 1'b1;
            res.copy_index  = COPY_W'(best_copy);
            res.chosen_slot = SLOT_W'(best_slot);
        end
        return res;
    endfunction

    // Mostly a node from the pool, otherwise any 8-bit id.
    function automatic logic [NODE_W-1:0] some_node(input int pool_pct);
        if ($urandom_range(99) < pool_pct)
            return NODE_POOL[$urandom_range(5)];
        return NODE_W'($urandom_range(255));
    endfunction

    // Random request: picks dominate; unused fields carry random junk.
    function automatic in_item_t random_request();
        in_item_t req;
        req.action     = ($urandom_range(99) < 65) ? ACT_PICK : ACT_ASSIGN;
        req.slot       = SLOT_W'($urandom_range(15));
        req.node_ident = some_node(80);
        req.copy0_node = some_node(75);
        req.copy1_node = some_node(75);
        req.copy2_node = some_node(75);
        return req;
    endfunction

    task automatic flag_error(input string msg);
        if (errors < 10)
            $display("%t  ERROR: %s", $realtime, msg);
        errors++;
    endtask

    // Present one request and hold it until the transfer. Starts with a
    // falling edge and returns at the accepting rising edge, so in_valid is
    // never driven twice in one time step.
    task automatic offer(input in_item_t req, input bit typed, input out_item_t want);
        out_item_t pred;
        int        gap;
        gap = 0;
        while (gap < MAX_GAP && $urandom_range(99) < send_idle_pct)
            gap++;
        @(negedge clk);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_item  <= req;
        in_valid <= 1'b1;
        do
            @(posedge clk);
        while (!in_ready);
        pred = pick_replica(req);
        pending_results.push_back(typed ? want : pred);
        requests_sent++;
        if (req.action == ACT_PICK && !pred.found)
            picks_missed++;
    endtask

    // Stop offering and wait for every outstanding result.
    task automatic pause_until_drained();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(negedge clk);
    endtask

    // Register writes happen only with the block empty and quiet.
    task automatic write_nodes_in_use(input logic [CFG_W-1:0] value);
        pause_until_drained();
        repeat (SETTLE) @(negedge clk);
        cfg_data <= value;
        cfg_we   <= 1'b1;
        @(negedge clk);
        cfg_we       <= 1'b0;
        slots_in_use  = value;
        cfg_writes++;
    endtask

    // Result side: random stalls per cycle, or a long forced hold-off that
    // lets the block back up into its input.
    initial
    begin
        out_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_left > 0)
            begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else
                out_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Every result transfer is checked against the oldest expectation.
    always @(posedge clk)
    begin : result_check
        out_item_t want;
        if (rst_n && out_valid && out_ready)
        begin
            results_checked++;
            if (pending_results.size() == 0)
                flag_error($sformatf("result with nothing expected: found=%0d copy=%0d slot=%0d",
                                     out_item.found, out_item.copy_index, out_item.chosen_slot));
            else
            begin
                want = pending_results.pop_front();
                if (out_item.found !== want.found || out_item.copy_index !== want.copy_index
                    || out_item.chosen_slot !== want.chosen_slot)
                    flag_error($sformatf({"result %0d: expected found=%0d copy=%0d slot=%0d, ",
                                          "got found=%0d copy=%0d slot=%0d"},
                                         results_checked, want.found, want.copy_index,
                                         want.chosen_slot, out_item.found,
                                         out_item.copy_index, out_item.chosen_slot));
            end
        end
    end

    // Watchdog: any transfer on either side counts as progress.
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("%t  no transfer for %0d cycles, %0d results outstanding",
                     $realtime, quiet_cycles, pending_results.size());
            $display("replica_least_loaded_picker_top regression: fail");
            $finish;
        end
    end

    initial
    begin : stimulus
        int       value;
        rst_n          = 1'b0;
        in_valid       = 1'b0;
        in_item        = '0;
        cfg_we         = 1'b0;
        cfg_data       = CFG_RESET;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_left      = 0;
        errors         = 0;
        requests_sent  = 0;
        picks_missed   = 0;
        results_checked = 0;
        cfg_writes     = 0;
        quiet_cycles   = 0;
        slots_in_use   = CFG_RESET;
        for (int s = 0; s < TABLE_DEPTH; s++)
        begin
            node_ids[s]   = '0;
            slot_loads[s] = '0;
        end

        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed table, back to back with no stalls.
        for (int r = 0; r < $size(DIRECTED); r++)
        begin
            if (DIRECTED[r].kind == ROW_CFG)
                write_nodes_in_use(DIRECTED[r].cfg);
            else
                offer(DIRECTED[r].req, DIRECTED[r].typed, DIRECTED[r].want);
        end

        // Random phases across register settings and idling patterns.
        for (int p = 0; p < $size(PHASES); p++)
        begin
            value = (PHASES[p].cfg < 0) ? $urandom_range(15, 2) : PHASES[p].cfg;
            write_nodes_in_use(CFG_W'(value));
            send_idle_pct  = PHASES[p].send_pct;
            recv_stall_pct = PHASES[p].recv_pct;
            for (int i = 0; i < PHASES[p].items; i++)
            begin
                // long receiver hold-off while requests keep coming
                if (p == 0 && i == 40)
                    hold_left = HOLD_OFF;
                if (i == PHASES[p].items / 2)
                    pause_until_drained();
                offer(random_request(), 1'b0, '0);
            end
        end

        pause_until_drained();
        repeat (SETTLE) @(posedge clk);
        if (pending_results.size() != 0)
            flag_error($sformatf("%0d results never arrived", pending_results.size()));

        $display("Covered %0d requests (%0d picks found no replica) and %0d checked results",
                 requests_sent, picks_missed, results_checked);
        $display("over %0d nodes_in_use writes, backpressure and idle mixes",
                 cfg_writes);
        if (errors == 0)
            $display("replica_least_loaded_picker_top regression: pass");
        else
            $display("replica_least_loaded_picker_top regression: fail");
        $finish;
    end

endmodule
